// ===== src/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants of the fair share width allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int WIDTH_W = 16;
    localparam int MINW_W  = 8;
    localparam int SUM_W   = 20;
    localparam int CHROME  = 3;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_TOTAL_WIDTH = 1'b0;
    localparam cfg_index_t CFG_MIN_WIDTH   = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0] natural_width;
        logic               last_column;
    } col_item_t;

    typedef struct packed {
        logic loading;
        logic emitting;
    } back_status_t;

endpackage

// ===== src/fsa_queue.sv =====
// ----------------------------------------------------------------------------
// fsa_queue
// Four entry request queue between the input channel and the fitting engine.
// ----------------------------------------------------------------------------
module fsa_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fsa_pkg::col_item_t push_item,
    output logic               not_full,
    input  logic               pop,
    output logic               head_valid,
    output fsa_pkg::col_item_t head_item
);

    fsa_pkg::col_item_t slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign not_full   = (count_reg != 3'd4);
    assign head_valid = (count_reg != 3'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 3'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/fsa_divider.sv =====
// ----------------------------------------------------------------------------
// fsa_divider
// Restoring divider, one quotient bit per cycle, for the fair share.
// ----------------------------------------------------------------------------
module fsa_divider #(
    parameter int DIV_W = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fsa_pkg::WIDTH_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       done,
    output logic [fsa_pkg::WIDTH_W-1:0] quotient,
    output logic [DIV_W-1:0]           remainder
);

    localparam int QW = fsa_pkg::WIDTH_W;

    logic [QW-1:0]    q_reg;
    logic [DIV_W-1:0] r_reg;
    logic [DIV_W-1:0] d_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic             fits;
    logic [DIV_W:0]   diff;

    assign trial = {r_reg, q_reg[QW-1]};
    assign fits  = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[QW-2:0], fits};
            r_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

endmodule

// ===== src/fsa_back.sv =====
// ----------------------------------------------------------------------------
// fsa_back
// Column store, water-filling sequencer and result emission.
// ----------------------------------------------------------------------------
module fsa_back #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  fsa_pkg::col_item_t          head_item,
    output logic                        pop,
    input  logic [fsa_pkg::WIDTH_W-1:0] total_width,
    input  logic [fsa_pkg::MINW_W-1:0]  min_width,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fsa_pkg::WIDTH_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast,
    output fsa_pkg::back_status_t       status
);

    localparam int WW  = fsa_pkg::WIDTH_W;
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int IW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int FSW = WW + CW;
    localparam int BW  = WW + 2;

    typedef enum logic [7:0] {
        ST_LOAD   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_SUM    = 8'b0000_0100,
        ST_EVAL   = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_MARK   = 8'b0010_0000,
        ST_ASSIGN = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [WW-1:0]          store_reg [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] fixed_reg;
    logic [CW-1:0]          count_reg;
    logic [fsa_pkg::SUM_W-1:0] sum_reg;
    logic                   ovf_reg;
    logic                   wrap_reg;
    logic [CW-1:0]          idx_reg;
    logic [FSW-1:0]         fsum_reg;
    logic [CW-1:0]          flex_reg;
    logic                   found_reg;
    logic [CW-1:0]          k_reg;
    logic [WW-1:0]          cap_reg;

    logic                   out_valid_reg;
    logic [WW-1:0]          out_width_reg;
    logic                   out_wrap_reg;
    logic                   out_ovf_reg;
    logic                   out_last_reg;

    logic [IW-1:0]          idx;
    logic [WW-1:0]          cur_w;
    logic                   cur_fixed;
    logic                   idx_last;
    logic signed [BW-1:0]   budget;
    logic [CW+fsa_pkg::MINW_W-1:0] need;
    logic                   div_start;
    logic                   div_done;
    logic [WW-1:0]          fair;
    logic [CW-1:0]          rem;
    logic                   hit;
    logic                   out_free;
    logic                   full;

    assign idx       = idx_reg[IW-1:0];
    assign cur_w     = store_reg[idx];
    assign cur_fixed = fixed_reg[idx];
    assign idx_last  = (idx_reg == count_reg - CW'(1));
    assign full      = (count_reg == CW'(MAX_COLUMNS));
    assign budget    = $signed({2'b00, total_width}) - BW'(1)
                       - $signed(BW'(fsa_pkg::CHROME) * BW'(count_reg));
    assign need      = (CW + fsa_pkg::MINW_W)'(count_reg) * (CW + fsa_pkg::MINW_W)'(min_width);
    assign hit       = !cur_fixed && (cur_w <= fair);
    assign out_free  = !out_valid_reg || m_tready;
    assign div_start = (state_reg == ST_EVAL) && (flex_reg != '0)
                       && (fsum_reg < FSW'(cap_reg));
    assign pop       = (state_reg == ST_LOAD) && head_valid;

    assign status.loading  = (state_reg == ST_LOAD);
    assign status.emitting = (state_reg == ST_EMIT);

    fsa_divider #(.DIV_W(CW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (cap_reg - fsum_reg[WW-1:0]),
        .divisor   (flex_reg),
        .done      (div_done),
        .quotient  (fair),
        .remainder (rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            fixed_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (head_valid) begin
                        if (!full) begin
                            count_reg <= count_reg + CW'(1);
                            sum_reg   <= sum_reg + fsa_pkg::SUM_W'(head_item.natural_width);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (head_item.last_column) begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    idx_reg <= '0;
                    cap_reg <= budget[WW-1:0];
                    if (budget[BW-1] || budget == '0
                            || sum_reg <= fsa_pkg::SUM_W'(budget[WW-1:0])
                            || FSW'(need) > FSW'(budget[WW-1:0])) begin
                        wrap_reg  <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else begin
                        wrap_reg  <= 1'b1;
                        fsum_reg  <= '0;
                        flex_reg  <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (cur_fixed) begin
                        fsum_reg <= fsum_reg + FSW'(cur_w);
                    end else begin
                        flex_reg <= flex_reg + CW'(1);
                    end
                    if (idx_last) begin
                        state_reg <= ST_EVAL;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_EVAL: begin
                    idx_reg <= '0;
                    // stop when nothing is left to share
                    state_reg <= div_start ? ST_DIV : ST_EMIT;
                end
                ST_DIV: begin
                    found_reg <= 1'b0;
                    if (div_done) begin
                        state_reg <= ST_MARK;
                    end
                end
                ST_MARK: begin
                    if (hit) begin
                        fixed_reg[idx] <= 1'b1;
                    end
                    if (idx_last) begin
                        idx_reg  <= '0;
                        k_reg    <= '0;
                        fsum_reg <= '0;
                        flex_reg <= '0;
                        state_reg <= (found_reg || hit) ? ST_SUM : ST_ASSIGN;
                    end else begin
                        found_reg <= found_reg || hit;
                        idx_reg   <= idx_reg + CW'(1);
                    end
                end
                ST_ASSIGN: begin
                    if (!cur_fixed) begin
                        k_reg <= k_reg + CW'(1);
                    end
                    if (idx_last) begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_width_reg <= cur_w;
                        out_wrap_reg  <= wrap_reg;
                        out_ovf_reg   <= ovf_reg;
                        out_last_reg  <= idx_last;
                        if (idx_last) begin
                            // close the run
                            count_reg <= '0;
                            sum_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            fixed_reg <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !full) begin
            store_reg[count_reg[IW-1:0]] <= head_item.natural_width;
        end else if (state_reg == ST_ASSIGN && !cur_fixed) begin
            store_reg[idx] <= fair + ((k_reg < rem) ? WW'(1) : WW'(0));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_width_reg;
    assign m_tuser  = {out_ovf_reg, out_wrap_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/fair_share_width_allocator.sv =====
// Columns are loaded from the queue and the budget is checked; each water-filling
// pass is a column scan, a divider start, a wait on the divider and a marking scan,
// and a closing scan spreads the fair share; then one result per cycle while m_tready is
// high. The next run's columns wait in the four entry queue until this run is emitted.
// Reset: synchronous, active low; clears queue, run state and output valid;
// registers return to total_width 80 and min_width 3.
// ----------------------------------------------------------------------------
// fair_share_width_allocator
// Max-min fair share column width fitting with decoupled input queue.
// ----------------------------------------------------------------------------
module fair_share_width_allocator #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // natural_width[15:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // final_width[15:0]
    output logic [1:0]  m_tuser,   // wrap[0], overflow[1]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [fsa_pkg::WIDTH_W-1:0] total_width_reg;
    logic [fsa_pkg::MINW_W-1:0]  min_width_reg;
    fsa_pkg::col_item_t          in_item;
    fsa_pkg::col_item_t          head_item;
    fsa_pkg::back_status_t       status;
    logic                        head_valid;
    logic                        q_pop;
    logic                        q_push;

    assign in_item.natural_width = s_tdata;
    assign in_item.last_column   = s_tlast;
    assign q_push = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_width_reg <= 16'd80;
            min_width_reg   <= 8'd3;
        end else if (cfg_we) begin
            case (cfg_index)
                fsa_pkg::CFG_TOTAL_WIDTH: total_width_reg <= cfg_data;
                fsa_pkg::CFG_MIN_WIDTH:   min_width_reg   <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fsa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (in_item),
        .not_full   (s_tready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    fsa_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (q_pop),
        .total_width (total_width_reg),
        .min_width   (min_width_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .status      (status)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> head_valid) else $error("queue popped while empty");
    a_no_pop_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        status.emitting |-> !q_pop) else $error("request taken during emission");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready) else $error("reset left state behind");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams column widths into the fair share width allocator and compares
// every fitted width, wrap, overflow and end flag with a local prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS = 16;

    typedef struct {
        logic [15:0] width;
        logic        wrap;
        logic        overflow;
        logic        last;
    } col_result_t;

    class width_scoreboard;
        logic [15:0] total_width;
        logic [7:0]  min_width;
        logic [15:0] widths[NCOLS];
        int          count;
        int          sum;
        bit          ovf;
        col_result_t pending[$];
        int          errors;

        function new();
            total_width = 16'd80;
            min_width   = 8'd3;
            count = 0;
            sum   = 0;
            ovf   = 1'b0;
            errors = 0;
        endfunction

        function bit fit();
            longint budget;
            int     cap;
            bit     fixd[NCOLS];
            int     flex;
            int     fsum;
            int     avail;
            int     fair;
            int     rem;
            int     k;
            bit     found;
            if (total_width == 16'd0) return 1'b0;
            budget = longint'(total_width) - 1 - 3 * count;
            if (budget <= 0) return 1'b0;
            cap = int'(budget);
            if (sum <= cap) return 1'b0;
            if (count * int'(min_width) > cap) return 1'b0;
            for (int c = 0; c < NCOLS; c++) fixd[c] = 1'b0;
            for (int p = 0; p <= count; p++) begin
                flex = 0;
                fsum = 0;
                for (int c = 0; c < count; c++) begin
                    if (fixd[c]) fsum += int'(widths[c]);
                    else flex++;
                end
                if (flex == 0 || fsum >= cap) break;
                avail = cap - fsum;
                fair  = avail / flex;
                found = 1'b0;
                for (int c = 0; c < count; c++) begin
                    if (!fixd[c] && int'(widths[c]) <= fair) begin
                        fixd[c] = 1'b1;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    rem = avail % flex;
                    k = 0;
                    for (int c = 0; c < count; c++) begin
                        if (!fixd[c]) begin
                            widths[c] = 16'(fair + (k < rem ? 1 : 0));
                            k++;
                        end
                    end
                    break;
                end
            end
            return 1'b1;
        endfunction

        function void note_request(logic [15:0] w, logic last);
            bit          wr;
            col_result_t r;
            if (count < NCOLS) begin
                widths[count] = w;
                count++;
                sum = (sum + int'(w)) & 32'h000F_FFFF;
            end else begin
                ovf = 1'b1;
            end
            if (!last) return;
            wr = fit();
            for (int c = 0; c < count; c++) begin
                r.width    = widths[c];
                r.wrap     = wr;
                r.overflow = ovf;
                r.last     = (c + 1 == count);
                pending.push_back(r);
            end
            count = 0;
            sum   = 0;
            ovf   = 1'b0;
        endfunction

        function void check_result(logic [15:0] w, logic [1:0] u, logic l);
            col_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result width=%0d", w);
                return;
            end
            e = pending.pop_front();
            if (w !== e.width || u[0] !== e.wrap || u[1] !== e.overflow
                    || l !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp w=%0d wrap=%0b ovf=%0b last=%0b",
                              " got w=%0d wrap=%0b ovf=%0b last=%0b"},
                             e.width, e.wrap, e.overflow, e.last, w, u[0], u[1], l);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    fsa_pkg::cfg_index_t cfg_index = fsa_pkg::CFG_TOTAL_WIDTH;
    logic [15:0] cfg_data = '0;

    width_scoreboard sb = new();
    int  src_idle_pct = 38;
    int  snk_idle_pct = 38;
    bit  hold_sink = 1'b0;

    always #5 aclk = ~aclk;

    fair_share_width_allocator #(.MAX_COLUMNS(NCOLS)) dut (.*);

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // result side stall
    always @(posedge aclk) begin
        m_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
    end

    // valid stays up between back to back requests; the task drops it when pausing
    task automatic send_col(logic [15:0] w, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(fsa_pkg::cfg_index_t idx, logic [15:0] v);
        // drain, then let the sequencer settle before touching a register
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == fsa_pkg::CFG_TOTAL_WIDTH) sb.total_width = v;
        else sb.min_width = v[7:0];
    endtask

    function automatic logic [15:0] rand_width();
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'hFFFF;
            2: return 16'd0;
            default: return 16'($urandom_range(60));
        endcase
    endfunction

    task automatic send_table(int n);
        for (int i = 0; i < n; i++) send_col(rand_width(), i == n - 1);
    endtask

    initial begin
        int sent;
        int n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: fits, shrinks, too narrow, remainder spread, single column
        send_col(16'd10, 1'b0); send_col(16'd20, 1'b1);
        send_col(16'd50, 1'b0); send_col(16'd40, 1'b0); send_col(16'd5, 1'b1);
        send_col(16'hFFFF, 1'b0); send_col(16'hFFFF, 1'b0); send_col(16'd0, 1'b0);
        send_col(16'd30, 1'b1);
        send_col(16'd100, 1'b1);
        // overflow: 18 columns into 16 slots, last two dropped
        for (int i = 0; i < 18; i++) send_col(16'(i * 7), i == 17);
        write_reg(fsa_pkg::CFG_MIN_WIDTH, 16'd255);
        send_col(16'd200, 1'b0); send_col(16'd300, 1'b1);
        write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'd0);
        send_col(16'd500, 1'b0); send_col(16'd9, 1'b1);
        write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'hFFFF);
        write_reg(fsa_pkg::CFG_MIN_WIDTH, 16'd1);
        send_col(16'hFFFF, 1'b0); send_col(16'hFFFF, 1'b0); send_col(16'h8000, 1'b1);
        write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'd60);
        send_col(16'hAAAA, 1'b0); send_col(16'h5555, 1'b1);

        // pressure: sink holds off while tables keep coming
        fork
            begin
                hold_sink = 1'b1;
                repeat (600) @(posedge aclk);
                hold_sink = 1'b0;
            end
            begin
                src_idle_pct = 0;
                send_table(16); send_table(12); send_table(16);
                s_tvalid <= 1'b0;
            end
        join
        src_idle_pct = 38;

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'd80);
                         write_reg(fsa_pkg::CFG_MIN_WIDTH, 16'd3); end
                1: begin write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'($urandom_range(30, 200)));
                         write_reg(fsa_pkg::CFG_MIN_WIDTH, 16'($urandom_range(1, 10))); end
                2: begin write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'($urandom_range(65535)));
                         write_reg(fsa_pkg::CFG_MIN_WIDTH, 16'($urandom_range(1, 255)));
                         src_idle_pct = 0; snk_idle_pct = 0; end
                3: begin write_reg(fsa_pkg::CFG_TOTAL_WIDTH, 16'd120);
                         write_reg(fsa_pkg::CFG_MIN_WIDTH, 16'd2);
                         src_idle_pct = 38; snk_idle_pct = 38; end
                default: begin
                end
            endcase
            while (sent < (ph + 1) * 25) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
                send_table(n);
                sent += n;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("fair_share_width_allocator test passed");
        end else begin
            $display("fair_share_width_allocator test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("fair_share_width_allocator test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/fsa_pkg.sv
src/fsa_queue.sv
src/fsa_divider.sv
src/fsa_back.sv
src/fair_share_width_allocator.sv
bench/tb_top.sv
